@@ sv/uart_bq_pkg.sv @@
// ----------------------------------------------------------------------------
// UART buffered queues package
// Operation, result and status codes, controller states and the control and
// flag structs shared between the ring and the top level.
// ----------------------------------------------------------------------------
package uart_bq_pkg;

	// Width of the burst limit register and the largest burst it may give.
	localparam int unsigned BURST_W   = 5;
	localparam int unsigned BURST_MAX = 16;

	typedef enum logic [1:0] {
		OP_PUT     = 2'd0,
		OP_GET     = 2'd1,
		OP_RX_BYTE = 2'd2,
		OP_TX_DONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_RX     = 2'd1,
		KIND_LINE   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_TX_FULL  = 3'd1,
		STS_RX_EMPTY = 3'd2,
		STS_RX_DROP  = 3'd3,
		STS_TX_IDLE  = 3'd4
	} result_code_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_DECIDE = 2'd1,
		S_READ   = 2'd2,
		S_EMIT   = 2'd3
	} state_t;

	// Requests from the controller to one ring.
	typedef struct packed {
		logic push;
		logic pop;
	} ring_ctrl_t;

	// Occupancy flags reported by one ring.
	typedef struct packed {
		logic empty;
		logic full;
	} ring_flags_t;

endpackage

@@ sv/uart_bq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module uart_bq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/uart_bq_ring.sv @@
// ----------------------------------------------------------------------------
// UART byte ring
// Read position, write position and fill count around one byte RAM. A pop
// issues the RAM read at the read position; the byte is valid in the cycle after.
// ----------------------------------------------------------------------------
module uart_bq_ring #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  uart_bq_pkg::ring_ctrl_t  ctrl,
	input  logic [7:0]               wdata,
	output uart_bq_pkg::ring_flags_t flags,
	output logic [7:0]               rdata
);
	import uart_bq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [AW-1:0] rd_pos_q;
	logic [AW-1:0] wr_pos_q;
	logic [CW-1:0] count_q;

	// Advance a position, wrapping after the last entry.
	function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// Pointer and count update; the controller never pushes and pops together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q <= '0;
			wr_pos_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctrl.push) begin
				wr_pos_q <= next_pos(wr_pos_q);
				count_q  <= count_q + CW'(1);
			end else if (ctrl.pop) begin
				rd_pos_q <= next_pos(rd_pos_q);
				count_q  <= count_q - CW'(1);
			end
		end
	end

	assign flags.empty = (count_q == '0);
	assign flags.full  = (count_q == CW'(DEPTH));

	uart_bq_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.push),
		.waddr(wr_pos_q),
		.wdata(wdata),
		.re   (ctrl.pop),
		.raddr(rd_pos_q),
		.rdata(rdata)
	);

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> !flags.full)
		else $error("push into a full ring");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> !flags.empty)
		else $error("pop from an empty ring");
`endif

endmodule

@@ sv/uart_buffered_tx_rx_queues.sv @@
// ----------------------------------------------------------------------------
// UART buffered transmit and receive queues
// Transmit and receive byte rings with a controller that handles put, get,
// received-byte and transmit-complete requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in channel (operation, data_byte) under valid and
//   ready; results leave on the out channel (kind, data_out, status, last).
//   Every request gives one result, except a transmit-complete with queued
//   bytes, which gives one line byte per result up to the burst limit; last
//   marks the final result of a request.
//   One request is handled at a time. A request that needs no RAM read goes
//   through the decide and emit states before its result is registered at the
//   output; a get or a burst byte also goes through the read state, for the
//   registered read of the ring RAM. Each further byte of a burst goes through
//   the read and emit states again. in_ready is high only while the controller
//   is idle, so the next request is taken only once the controller returns there.
//   The result register is separate from the controller, so a new request is
//   taken while the previous final result waits to be transferred. When the
//   receiver stalls, the controller holds its next result until the output
//   register frees.
//   Reset empties both rings, marks the transmitter idle and sets the burst
//   limit to 16. Ring contents are not cleared and need no clearing pass.
//   cfg_wdata is written to the burst limit when cfg_we is high; 0 acts as 1
//   and values above 16 act as 16.
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_queues #(
	parameter int unsigned RING_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] data_out,
	output logic [2:0] status,
	output logic       last,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);
	import uart_bq_pkg::*;

	state_t             state_q, state_d;
	op_t                op_q;
	logic [7:0]         byte_q;
	logic               tx_busy_q, tx_busy_d;
	logic [BURST_W-1:0] burst_lim_q;
	logic [BURST_W-1:0] burst_eff;
	logic [BURST_W-1:0] burst_cnt_q, burst_cnt_d;

	kind_t              res_kind_q, res_kind_d;
	logic [7:0]         res_data_q, res_data_d;
	result_code_t       res_status_q, res_status_d;
	logic               res_last_q, res_last_d;

	logic               out_valid_q;
	logic               out_load;
	kind_t              out_kind_q;
	logic [7:0]         out_data_q;
	result_code_t       out_status_q;
	logic               out_last_q;

	ring_ctrl_t         tx_ctrl, rx_ctrl;
	ring_flags_t        tx_flags, rx_flags;
	logic [7:0]         tx_rdata, rx_rdata;

	// Rings.
	uart_bq_ring #(.DEPTH(RING_DEPTH)) u_tx_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (tx_ctrl),
		.wdata (byte_q),
		.flags (tx_flags),
		.rdata (tx_rdata)
	);

	uart_bq_ring #(.DEPTH(RING_DEPTH)) u_rx_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (rx_ctrl),
		.wdata (byte_q),
		.flags (rx_flags),
		.rdata (rx_rdata)
	);

	// Burst limit register and its clamped value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_lim_q <= BURST_W'(BURST_MAX);
		end else if (cfg_we) begin
			burst_lim_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (burst_lim_q == '0) begin
			burst_eff = BURST_W'(1);
		end else if (burst_lim_q > BURST_W'(BURST_MAX)) begin
			burst_eff = BURST_W'(BURST_MAX);
		end else begin
			burst_eff = burst_lim_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Request capture.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q   <= op_t'(operation);
			byte_q <= data_byte;
		end
	end

	// Controller state and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tx_busy_q   <= 1'b0;
			burst_cnt_q <= '0;
		end else begin
			state_q     <= state_d;
			tx_busy_q   <= tx_busy_d;
			burst_cnt_q <= burst_cnt_d;
		end
	end

	// Pending result held between the controller and the output register.
	always_ff @(posedge clk) begin
		res_kind_q   <= res_kind_d;
		res_data_q   <= res_data_d;
		res_status_q <= res_status_d;
		res_last_q   <= res_last_d;
	end

	// Next state, ring requests and the pending result.
	always_comb begin
		state_d      = state_q;
		tx_busy_d    = tx_busy_q;
		burst_cnt_d  = burst_cnt_q;
		res_kind_d   = res_kind_q;
		res_data_d   = res_data_q;
		res_status_d = res_status_q;
		res_last_d   = res_last_q;
		tx_ctrl      = '0;
		rx_ctrl      = '0;
		out_load     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				// Status-only result unless a branch says otherwise.
				res_kind_d   = KIND_STATUS;
				res_data_d   = '0;
				res_status_d = STS_OK;
				res_last_d   = 1'b1;
				state_d      = S_EMIT;
				unique case (op_q)
					OP_PUT: begin
						if (!tx_busy_q) begin
							tx_busy_d  = 1'b1;
							res_kind_d = KIND_LINE;
							res_data_d = byte_q;
						end else if (tx_flags.full) begin
							res_status_d = STS_TX_FULL;
						end else begin
							tx_ctrl.push = 1'b1;
						end
					end
					OP_GET: begin
						if (rx_flags.empty) begin
							res_status_d = STS_RX_EMPTY;
						end else begin
							rx_ctrl.pop = 1'b1;
							state_d     = S_READ;
						end
					end
					OP_RX_BYTE: begin
						if (rx_flags.full) begin
							res_status_d = STS_RX_DROP;
						end else begin
							rx_ctrl.push = 1'b1;
						end
					end
					OP_TX_DONE: begin
						if (tx_flags.empty) begin
							tx_busy_d    = 1'b0;
							res_status_d = STS_TX_IDLE;
						end else begin
							tx_ctrl.pop = 1'b1;
							burst_cnt_d = BURST_W'(1);
							state_d     = S_READ;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_READ: begin
				// The ring byte popped in the previous cycle is now valid.
				res_status_d = STS_OK;
				if (op_q == OP_TX_DONE) begin
					res_kind_d = KIND_LINE;
					res_data_d = tx_rdata;
					res_last_d = (burst_cnt_q == burst_eff) || tx_flags.empty;
				end else begin
					res_kind_d = KIND_RX;
					res_data_d = rx_rdata;
					res_last_d = 1'b1;
				end
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					if (res_last_q) begin
						state_d = S_IDLE;
					end else begin
						tx_ctrl.pop = 1'b1;
						burst_cnt_d = burst_cnt_q + BURST_W'(1);
						state_d     = S_READ;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q   <= res_kind_q;
			out_data_q   <= res_data_q;
			out_status_q <= res_status_q;
			out_last_q   <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = out_kind_q;
	assign data_out  = out_data_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

`ifndef NO_ASSERTIONS
	a_status_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_STATUS) |-> data_out == 8'd0)
		else $error("status-only result carries data");
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_STATUS) |-> status == STS_OK)
		else $error("data result carries an error status");
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in progress");
	a_ring_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!((tx_ctrl.push || tx_ctrl.pop) && (rx_ctrl.push || rx_ctrl.pop)))
		else $error("both rings accessed in one cycle");
`endif

endmodule

@@ test/uart_buffered_tx_rx_queues_tb.sv @@
// ----------------------------------------------------------------------------
// UART buffered queues testbench
// Drives put, get, received-byte and transmit-complete requests into the
// queue block, predicts each request's results from a behavioural copy of
// both rings, and compares every transferred result with the oldest
// prediction. A short scripted sequence is followed by ring-filling and
// random phases under several burst limits, with random idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_queues_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import uart_bq_pkg::*;

	localparam int RING_DEPTH  = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 800000;
	localparam int SCRIPT_LEN  = 20;

	// One result as it leaves the block.
	typedef struct {
		kind_t        kind;
		logic [7:0]   data;
		result_code_t status;
		logic         last;
	} uart_result_t;

	// One row of the scripted sequence; fixed rows carry their single result.
	typedef struct {
		op_t          op;
		logic [7:0]   data;
		bit           fixed;
		kind_t        kind;
		logic [7:0]   result_data;
		result_code_t status;
	} script_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [1:0] operation = OP_PUT;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_out;
	logic [2:0] status;
	logic       last;
	logic       cfg_we    = 1'b0;
	logic [4:0] cfg_wdata = 5'd0;

	// Behavioural copy of the rings and the burst limit.
	logic [7:0] tx_ring [RING_DEPTH];
	logic [7:0] rx_ring [RING_DEPTH];
	int         tx_head, tx_tail, tx_fill;
	int         rx_head, rx_tail, rx_fill;
	bit         line_busy;
	logic [4:0] burst_cfg;

	uart_result_t step_results [$];
	uart_result_t pending_results [$];
	uart_result_t head;

	int unsigned cycle_count     = 0;
	int unsigned mismatches      = 0;
	int unsigned results_checked = 0;
	int unsigned items_accepted  = 0;
	int unsigned settings_used   = 1;
	bit          src_idle_on     = 1'b1;
	bit          sink_idle_on    = 1'b1;
	bit          hold_ask        = 1'b0;
	bit          hold_seen       = 1'b0;
	int          sink_wait       = 0;

	script_row_t script [SCRIPT_LEN] = '{
		'{OP_GET,     8'h00, 1'b1, KIND_STATUS, 8'h00, STS_RX_EMPTY},
		'{OP_TX_DONE, 8'hFF, 1'b1, KIND_STATUS, 8'h00, STS_TX_IDLE},
		'{OP_PUT,     8'h00, 1'b1, KIND_LINE,   8'h00, STS_OK},
		'{OP_PUT,     8'hFF, 1'b1, KIND_STATUS, 8'h00, STS_OK},
		'{OP_PUT,     8'h5A, 1'b0, KIND_STATUS, 8'h00, STS_OK},
		'{OP_PUT,     8'hA5, 1'b0, KIND_STATUS, 8'h00, STS_OK},
		'{OP_TX_DONE, 8'h00, 1'b0, KIND_STATUS, 8'h00, STS_OK},
		'{OP_TX_DONE, 8'h00, 1'b1, KIND_STATUS, 8'h00, STS_TX_IDLE},
		'{OP_TX_DONE, 8'h00, 1'b1, KIND_STATUS, 8'h00, STS_TX_IDLE},
		'{OP_RX_BYTE, 8'h00, 1'b1, KIND_STATUS, 8'h00, STS_OK},
		'{OP_RX_BYTE, 8'hFF, 1'b1, KIND_STATUS, 8'h00, STS_OK},
		'{OP_RX_BYTE, 8'h3C, 1'b0, KIND_STATUS, 8'h00, STS_OK},
		'{OP_GET,     8'hFF, 1'b1, KIND_RX,     8'h00, STS_OK},
		'{OP_GET,     8'h00, 1'b1, KIND_RX,     8'hFF, STS_OK},
		'{OP_GET,     8'h00, 1'b0, KIND_STATUS, 8'h00, STS_OK},
		'{OP_GET,     8'h00, 1'b1, KIND_STATUS, 8'h00, STS_RX_EMPTY},
		'{OP_PUT,     8'h81, 1'b1, KIND_LINE,   8'h81, STS_OK},
		'{OP_PUT,     8'h7E, 1'b0, KIND_STATUS, 8'h00, STS_OK},
		'{OP_TX_DONE, 8'h00, 1'b0, KIND_STATUS, 8'h00, STS_OK},
		'{OP_TX_DONE, 8'h00, 1'b1, KIND_STATUS, 8'h00, STS_TX_IDLE}
	};

	uart_buffered_tx_rx_queues #(
		.RING_DEPTH(RING_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.data_out (data_out),
		.status   (status),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Free-running clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, pending_results.size());
			$display("FAIL");
			$finish;
		end
	end

	// Mostly short gaps with the odd long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Works out the results of one request and advances the ring copy.
	function automatic void predict_uart_results(input op_t op, input logic [7:0] b);
		int lim;
		int n;
		step_results.delete();
		case (op)
			OP_PUT: begin
				if (!line_busy) begin
					line_busy = 1'b1;
					step_results.push_back('{KIND_LINE, b, STS_OK, 1'b1});
				end else if (tx_fill >= RING_DEPTH) begin
					step_results.push_back('{KIND_STATUS, 8'h00, STS_TX_FULL, 1'b1});
				end else begin
					tx_ring[tx_tail] = b;
					tx_tail = (tx_tail + 1) % RING_DEPTH;
					tx_fill++;
					step_results.push_back('{KIND_STATUS, 8'h00, STS_OK, 1'b1});
				end
			end
			OP_GET: begin
				if (rx_fill == 0) begin
					step_results.push_back('{KIND_STATUS, 8'h00, STS_RX_EMPTY, 1'b1});
				end else begin
					step_results.push_back('{KIND_RX, rx_ring[rx_head], STS_OK, 1'b1});
					rx_head = (rx_head + 1) % RING_DEPTH;
					rx_fill--;
				end
			end
			OP_RX_BYTE: begin
				if (rx_fill < RING_DEPTH) begin
					rx_ring[rx_tail] = b;
					rx_tail = (rx_tail + 1) % RING_DEPTH;
					rx_fill++;
					step_results.push_back('{KIND_STATUS, 8'h00, STS_OK, 1'b1});
				end else begin
					step_results.push_back('{KIND_STATUS, 8'h00, STS_RX_DROP, 1'b1});
				end
			end
			default: begin
				if (tx_fill == 0) begin
					line_busy = 1'b0;
					step_results.push_back('{KIND_STATUS, 8'h00, STS_TX_IDLE, 1'b1});
				end else begin
					// A zero limit still sends one byte; anything over the
					// maximum is clamped to it.
					lim = (burst_cfg == 0) ? 1 : int'(burst_cfg);
					if (lim > BURST_MAX)
						lim = BURST_MAX;
					n = (tx_fill < lim) ? tx_fill : lim;
					for (int k = 0; k < n; k++) begin
						step_results.push_back('{KIND_LINE, tx_ring[tx_head], STS_OK,
							logic'(k == n - 1)});
						tx_head = (tx_head + 1) % RING_DEPTH;
						tx_fill--;
					end
				end
			end
		endcase
	endfunction

	// Offers one request, holds it until the transfer, then records what
	// should come back. Fixed rows use their own result instead.
	task automatic offer(input op_t op, input logic [7:0] b, input bit fixed,
			input uart_result_t fixed_res);
		int gap;
		gap = (!src_idle_on || $urandom_range(0, 99) < 55) ? 0 : gap_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		data_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		items_accepted++;
		predict_uart_results(op, b);
		if (fixed)
			pending_results.push_back(fixed_res);
		else
			foreach (step_results[i])
				pending_results.push_back(step_results[i]);
	endtask

	// Stops offering and waits until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes the burst limit; only called while the block is idle.
	task automatic write_burst(input logic [4:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		burst_cfg = v;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// A run of random requests with the given percentages of put, get and
	// received byte; the remainder are transmit-complete events.
	task automatic random_mix(input int count, input int w_put, input int w_get,
			input int w_rx);
		int   r;
		op_t  op;
		uart_result_t none;
		none = '{KIND_STATUS, 8'h00, STS_OK, 1'b1};
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < w_put)
				op = OP_PUT;
			else if (r < w_put + w_get)
				op = OP_GET;
			else if (r < w_put + w_get + w_rx)
				op = OP_RX_BYTE;
			else
				op = OP_TX_DONE;
			offer(op, 8'($urandom_range(0, 255)), 1'b0, none);
		end
	endtask

	// Receiver side: random ready gaps, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			sink_wait <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (sink_idle_on && $urandom_range(0, 99) < 15)
				sink_wait <= gap_length();
		end
	end

	// Checks each transferred result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result kind %0d data %02h status %0d last %0b",
						$time, kind, data_out, status, last);
			end else begin
				head = pending_results.pop_front();
				if (kind !== head.kind || data_out !== head.data ||
						status !== head.status || last !== head.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: expected kind %0d data %02h status %0d last %0b",
							$time, head.kind, head.data, head.status, head.last);
						$display("%0t:      got kind %0d data %02h status %0d last %0b",
							$time, kind, data_out, status, last);
					end
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin : stimulus
		uart_result_t row_res;
		uart_result_t none;
		none = '{KIND_STATUS, 8'h00, STS_OK, 1'b1};

		// Reset state of the ring copy; the block leaves reset with limit 16.
		tx_head = 0; tx_tail = 0; tx_fill = 0;
		rx_head = 0; rx_tail = 0; rx_fill = 0;
		line_busy = 1'b0;
		burst_cfg = 5'd16;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Scripted sequence under the reset burst limit.
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			row_res = '{script[i].kind, script[i].result_data, script[i].status, 1'b1};
			offer(script[i].op, script[i].data, script[i].fixed, row_res);
		end
		drain();

		// Start filling the transmit ring past full while the receiver holds off,
		// then drain it in full-length bursts.
		write_burst(5'd31);
		hold_ask <= ~hold_ask;
		for (int i = 0; i < RING_DEPTH + 3; i++)
			offer(OP_PUT, 8'($urandom_range(0, 255)), 1'b0, none);
		for (int i = 0; i < 5; i++)
			offer(OP_TX_DONE, 8'($urandom_range(0, 255)), 1'b0, none);
		drain();

		// Fill the receive ring past full, then take bytes from it with a get-heavy mix.
		write_burst(5'd0);
		for (int i = 0; i < RING_DEPTH + 2; i++)
			offer(OP_RX_BYTE, 8'($urandom_range(0, 255)), 1'b0, none);
		random_mix(30, 30, 45, 10);
		drain();

		// A stretch without idling on either side.
		write_burst(5'd1);
		src_idle_on  <= 1'b0;
		sink_idle_on <= 1'b0;
		random_mix(25, 35, 20, 25);
		drain();

		src_idle_on  <= 1'b1;
		sink_idle_on <= 1'b1;
		write_burst(5'd17);
		random_mix(25, 45, 20, 20);
		drain();

		write_burst(5'($urandom_range(2, 15)));
		random_mix(25, 35, 20, 25);
		drain();

		write_burst(5'd16);
		random_mix(20, 40, 20, 20);
		drain();

		// Let any stray result show up before the verdict.
		repeat (40) @(posedge clk);

		if (pending_results.size() != 0) begin
			mismatches++;
			$display("%0d predicted results never arrived.", pending_results.size());
		end
		$display("Covered %0d requests and %0d results over %0d burst-limit settings.",
			items_accepted, results_checked, settings_used);
		$display("Both rings were pushed past full; the receiver stalled %0d cycles once.",
			HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches in total.", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/uart_bq_pkg.sv
sv/uart_bq_ram.sv
sv/uart_bq_ring.sv
sv/uart_buffered_tx_rx_queues.sv
test/uart_buffered_tx_rx_queues_tb.sv
